/* rtl/csv_pkg.sv */
// Package for the collision slide velocity block: widths, payload types and
// the small arithmetic helpers used by the pipeline modules.
// Depends on nothing; the RTL modules refer to it by scoped names, the test files import it.
package csv_pkg;

  // Field widths.
  localparam int VEL_W = 24;
  localparam int NRM_W = 16;
  localparam int STOP_W = 23;
  localparam int SQ_W = 2 * STOP_W;

  // Internal widths of the projection.
  localparam int NV_W = VEL_W + NRM_W;
  localparam int DOT26_W = NV_W + 2;
  localparam int RND_W = 48;
  localparam int ROUND_SH = 14;
  localparam int DOT_W = 28;
  localparam int ND_W = NRM_W + DOT_W;
  localparam int PR_W = 30;
  localparam int DIFF_W = PR_W + 1;
  localparam int R_W = 28;
  localparam int RSQ_W = 2 * R_W;
  localparam int R2_W = 56;
  localparam int VSQ_W = 2 * VEL_W;
  localparam int V2_W = 48;

  // Square root and division.
  localparam int ROOT_STEPS = R2_W / 2;
  localparam int MAGV_W = 24;
  localparam int MAGR_W = 28;
  localparam int Q_W = 24;
  localparam int DEN_W = MAGR_W + 1;
  localparam int PROD_W = R_W + MAGV_W;
  localparam int NUM_W = PROD_W + 1;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [0:0] REG_STOP_SPEED = 1'b0;
  localparam logic [STOP_W-1:0] STOP_RESET = 23'd205;
  localparam logic [SQ_W-1:0] STOP_SQ_RESET = {{(SQ_W - STOP_W){1'b0}}, STOP_RESET}
                                            * {{(SQ_W - STOP_W){1'b0}}, STOP_RESET};

  localparam logic signed [VEL_W-1:0] VEL_MAX = 24'sh7FFFFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 24'sh800000;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_STOP,
    MODE_SLIDE
  } mode_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    same_parent;
  } in_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] out_vx;
    logic signed [VEL_W-1:0] out_vy;
    logic signed [VEL_W-1:0] out_vz;
    logic                    moving;
    logic                    parent_mismatch;
  } out_t;

  // Per-item data that rides along with the square roots and the divider.
  typedef struct packed {
    logic [2:0][R_W-1:0]   r;
    logic [2:0][VEL_W-1:0] v;
    mode_t                 mode;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [V2_W-1:0]  v2;
    logic [R2_W-1:0]  r2;
  } mid_t;

  typedef struct packed {
    side_t              side;
    logic [MAGV_W-1:0]  mag_v;
    logic [MAGR_W-1:0]  mag_r;
  } root_t;

  typedef struct packed {
    logic [R2_W-1:0] x;
    logic [R2_W-1:0] res;
  } root_st_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [Q_W-1:0]   nq;
  } div_st_t;

  // Drop ROUND_SH fraction bits, rounding half away from zero.
  function automatic logic signed [RND_W-1:0] rnd_shift(input logic signed [RND_W-1:0] x);
    logic [RND_W-1:0] mag;
    logic [RND_W-1:0] q;
    mag = x[RND_W-1] ? (~x + 1'b1) : x;
    q = (mag + (RND_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
    return x[RND_W-1] ? $signed(~q + 1'b1) : $signed(q);
  endfunction

  // One step of the bit-by-bit integer square root.
  function automatic root_st_t root_step(input root_st_t s, input logic [R2_W-1:0] b);
    root_st_t         o;
    logic [R2_W-1:0]  t;
    t = s.res + b;
    if (s.x >= t) begin
      o.x = s.x - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.x = s.x;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // One quotient bit of a restoring division; numerator bits shift out of nq
  // at the top while quotient bits shift in at the bottom.
  function automatic div_st_t div_step(input div_st_t s, input logic [DEN_W-1:0] den);
    div_st_t        o;
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;
    t = {s.rem, s.nq[Q_W-1]};
    diff = t - {1'b0, den};
    ge = (t >= {1'b0, den});
    o.rem = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
    o.nq = {s.nq[Q_W-2:0], ge};
    return o;
  endfunction

  // Apply the sign to a magnitude and clamp to the velocity range.
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic [Q_W-1:0] q,
                                                      input logic neg);
    logic [Q_W-1:0] nq;
    nq = ~q + 1'b1;
    if (!neg) begin
      return q[Q_W-1] ? VEL_MAX : $signed(q);
    end
    return (q[Q_W-1] && (q[Q_W-2:0] != '0)) ? VEL_MIN : $signed(nq);
  endfunction

endpackage

/* rtl/csv_stream_if.sv */
// Valid/ready stream interface used for the item and result channels.
// The payload type is a parameter; the types come from csv_pkg.
interface csv_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/collision_slide_velocity_top.sv */
// Top level of the collision slide velocity block: stop-speed register on
// the APB-style port and the three pipeline sections.
// Depends on csv_pkg, csv_stream_if, csv_proj, csv_sqrt and csv_div.
//
//   Channel   Direction  Handshake              Payload
//   in_s      sink       valid/ready            velocity, normal, same_parent
//   out_s     source     valid/ready            velocity, moving, parent_mismatch
//   APB       slave      psel/penable/pready    stop_speed at byte address 0
//
// The block takes one item per clock cycle while the result side does not
// stall and returns the results in order. The depth comes mostly from the
// 28-stage square root, which yields one bit of both roots per stage, and
// from the 24-stage divider, which yields one quotient bit per stage.
// Reset is synchronous and active low; it empties the pipeline and loads the
// stop speed with its reset value.
// When the result side stalls, each pipeline section holds while its last
// stage is full; sections with room keep taking transfers.
module collision_slide_velocity_top (
  input  logic                          clk,
  input  logic                          rst_n,
  csv_stream_if.sink                    in_s,
  csv_stream_if.source                  out_s,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csv_pkg::APB_AW-1:0]    paddr,
  input  logic [csv_pkg::APB_DW-1:0]    pwdata,
  output logic [csv_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  localparam int APB_DW = csv_pkg::APB_DW;

  // The stop speed and its square. The square is registered in the cycle after
  // the stop speed. The user must change the configuration only while the block
  // is idle; the block does not enforce this. Then no item sees the two disagree.
  logic [csv_pkg::STOP_W-1:0] stop_r;
  logic [csv_pkg::STOP_W-1:0] stop_nxt;
  logic [csv_pkg::SQ_W-1:0]   stop_sq_r;
  logic [csv_pkg::SQ_W-1:0]   stop_sq_nxt;

  // Handshakes between the sections.
  logic          proj_valid;
  logic          proj_ready;
  csv_pkg::mid_t proj_data;
  logic          root_valid;
  logic          root_ready;
  csv_pkg::root_t root_data;

  assign pready = 1'b1;

  // Register decode: a write lands on the access cycle.
  always_comb begin
    stop_nxt = stop_r;
    prdata = '0;
    unique case (paddr[csv_pkg::APB_AW-1:2])
      csv_pkg::REG_STOP_SPEED: begin
        prdata = APB_DW'(stop_r);
        if (psel && penable && pwrite) begin
          stop_nxt = pwdata[csv_pkg::STOP_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign stop_sq_nxt = csv_pkg::SQ_W'(stop_r) * csv_pkg::SQ_W'(stop_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_r <= csv_pkg::STOP_RESET;
      stop_sq_r <= csv_pkg::STOP_SQ_RESET;
    end else begin
      stop_r <= stop_nxt;
      stop_sq_r <= stop_sq_nxt;
    end
  end

  // Nine stages: products, sums, rounding, projection, remaining vector,
  // its squared length and the stop-speed test.
  csv_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_ready  (in_s.ready),
    .in_data   (in_s.data),
    .out_valid (proj_valid),
    .out_ready (proj_ready),
    .out_data  (proj_data),
    .stop_sq   (stop_sq_r)
  );

  // Twenty-eight stages: both speeds as floor square roots.
  csv_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (proj_valid),
    .in_ready  (proj_ready),
    .in_data   (proj_data),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_data  (root_data)
  );

  // Twenty-seven stages: scale, divide with rounding, select and saturate.
  // Its last stage is the result register seen on out_s.
  csv_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (root_valid),
    .in_ready  (root_ready),
    .in_data   (root_data),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .out_data  (out_s.data)
  );

endmodule

/* rtl/csv_proj.sv */
// Projection pipeline: dot product, removal of the normal component and the
// squared magnitudes, then the stop-speed test. Uses csv_pkg.
module csv_proj (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  csv_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output csv_pkg::mid_t             out_data,
  input  logic [csv_pkg::SQ_W-1:0]  stop_sq
);
  localparam int NST = 9;
  localparam int DOT26_W = csv_pkg::DOT26_W;
  localparam int RND_W = csv_pkg::RND_W;
  localparam int DIFF_W = csv_pkg::DIFF_W;
  localparam int R2_W = csv_pkg::R2_W;
  localparam int V2_W = csv_pkg::V2_W;
  localparam int VEL_W = csv_pkg::VEL_W;
  localparam int NRM_W = csv_pkg::NRM_W;

  logic [NST:1] vld_r;
  logic         en;

  logic signed [VEL_W-1:0] v_in [3];
  logic signed [NRM_W-1:0] n_in [3];

  logic signed [VEL_W-1:0]           vel_r [1:8][3];
  logic signed [NRM_W-1:0]           nrm_r [1:3][3];
  logic [8:1]                        sp_r;
  logic signed [csv_pkg::NV_W-1:0]   nv_r [3];
  logic signed [csv_pkg::VSQ_W-1:0]  vsq_r [3];
  logic signed [DOT26_W-1:0]         dot26_r;
  logic [V2_W-1:0]                   v2_r [2:8];
  logic signed [csv_pkg::DOT_W-1:0]  dot_r;
  logic signed [csv_pkg::ND_W-1:0]   nd_r [3];
  logic signed [csv_pkg::PR_W-1:0]   pr_r [3];
  logic signed [csv_pkg::R_W-1:0]    r_r [6:8][3];
  logic signed [csv_pkg::RSQ_W-1:0]  rsq_r [3];
  logic [R2_W-1:0]                   r2_r;
  csv_pkg::mid_t                     out_r;

  logic signed [RND_W-1:0]  dot_rnd;
  logic signed [RND_W-1:0]  pr_rnd [3];
  logic signed [DIFF_W-1:0] diff [3];
  csv_pkg::mode_t           mode_nxt;

  assign v_in[0] = in_data.vel_x;
  assign v_in[1] = in_data.vel_y;
  assign v_in[2] = in_data.vel_z;
  assign n_in[0] = in_data.normal_x;
  assign n_in[1] = in_data.normal_y;
  assign n_in[2] = in_data.normal_z;

  assign en = !vld_r[NST] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[NST];
  assign out_data = out_r;

  always_comb begin
    dot_rnd = csv_pkg::rnd_shift(RND_W'(dot26_r));
    for (int i = 0; i < 3; i++) begin
      pr_rnd[i] = csv_pkg::rnd_shift(RND_W'(nd_r[i]));
      diff[i] = DIFF_W'(vel_r[5][i]) - DIFF_W'(pr_r[i]);
    end
    if (!sp_r[8]) begin
      mode_nxt = csv_pkg::MODE_PASS;
    end else if (r2_r > R2_W'(stop_sq)) begin
      mode_nxt = csv_pkg::MODE_SLIDE;
    end else begin
      mode_nxt = csv_pkg::MODE_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r <= {sp_r[7:1], in_data.same_parent};
      for (int i = 0; i < 3; i++) begin
        vel_r[1][i] <= v_in[i];
        for (int k = 2; k <= 8; k++) begin
          vel_r[k][i] <= vel_r[k-1][i];
        end
        nrm_r[1][i] <= n_in[i];
        nrm_r[2][i] <= nrm_r[1][i];
        nrm_r[3][i] <= nrm_r[2][i];
        // Stage 1: products.
        nv_r[i] <= n_in[i] * v_in[i];
        vsq_r[i] <= v_in[i] * v_in[i];
        // Stage 4: normal times rounded dot product.
        nd_r[i] <= nrm_r[3][i] * dot_r;
        // Stage 5: rounded projection.
        pr_r[i] <= pr_rnd[i][csv_pkg::PR_W-1:0];
        // Stage 6: remaining vector.
        r_r[6][i] <= diff[i][csv_pkg::R_W-1:0];
        r_r[7][i] <= r_r[6][i];
        r_r[8][i] <= r_r[7][i];
        // Stage 7: squares of the remaining vector.
        rsq_r[i] <= r_r[6][i] * r_r[6][i];
      end
      // Stage 2: sums.
      dot26_r <= DOT26_W'(nv_r[0]) + DOT26_W'(nv_r[1]) + DOT26_W'(nv_r[2]);
      v2_r[2] <= $unsigned(vsq_r[0]) + $unsigned(vsq_r[1]) + $unsigned(vsq_r[2]);
      for (int k = 3; k <= 8; k++) begin
        v2_r[k] <= v2_r[k-1];
      end
      // Stage 3: dot product rounded to Q16.12.
      dot_r <= dot_rnd[csv_pkg::DOT_W-1:0];
      // Stage 8: squared length of the remaining vector.
      r2_r <= $unsigned(rsq_r[0]) + $unsigned(rsq_r[1]) + $unsigned(rsq_r[2]);
      // Stage 9: threshold test.
      for (int i = 0; i < 3; i++) begin
        out_r.side.r[i] <= r_r[8][i];
        out_r.side.v[i] <= vel_r[8][i];
      end
      out_r.side.mode <= mode_nxt;
      out_r.v2 <= v2_r[8];
      out_r.r2 <= r2_r;
    end
  end

endmodule

/* rtl/csv_sqrt.sv */
// Two pipelined integer square roots, one bit of each root per stage, for
// the speed before and after projection. Uses csv_pkg.
module csv_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  csv_pkg::mid_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output csv_pkg::root_t out_data
);
  localparam int NST = csv_pkg::ROOT_STEPS;
  localparam int R2_W = csv_pkg::R2_W;
  localparam logic [R2_W-1:0] ONE = 1;

  logic [NST-1:0]     vld_r;
  logic               en;
  csv_pkg::root_st_t  rv_r [NST];
  csv_pkg::root_st_t  rr_r [NST];
  csv_pkg::side_t     side_r [NST];

  assign en = !vld_r[NST-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[NST-1];

  always_comb begin
    out_data.side = side_r[NST-1];
    out_data.mag_v = rv_r[NST-1].res[csv_pkg::MAGV_W-1:0];
    out_data.mag_r = rr_r[NST-1].res[csv_pkg::MAGR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    csv_pkg::root_st_t v_prev;
    csv_pkg::root_st_t r_prev;
    csv_pkg::side_t    s_prev;

    if (k == 0) begin : g_first
      assign v_prev = '{x: R2_W'(in_data.v2), res: '0};
      assign r_prev = '{x: in_data.r2, res: '0};
      assign s_prev = in_data.side;
    end else begin : g_next
      assign v_prev = rv_r[k-1];
      assign r_prev = rr_r[k-1];
      assign s_prev = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rv_r[k] <= csv_pkg::root_step(v_prev, ONE << (R2_W - 2 - 2 * k));
        rr_r[k] <= csv_pkg::root_step(r_prev, ONE << (R2_W - 2 - 2 * k));
        side_r[k] <= s_prev;
      end
    end
  end

endmodule

/* rtl/csv_div.sv */
// Rescaling pipeline: scales each remaining component by the original speed
// over the remaining speed with a one-bit-per-stage divider, then selects and
// saturates the result. Uses csv_pkg.
module csv_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  csv_pkg::root_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output csv_pkg::out_t  out_data
);
  localparam int NDIV = csv_pkg::Q_W;
  localparam int NST = NDIV + 3;
  localparam int R_W = csv_pkg::R_W;
  localparam int PROD_W = csv_pkg::PROD_W;
  localparam int NUM_W = csv_pkg::NUM_W;
  localparam int Q_W = csv_pkg::Q_W;
  localparam int DEN_W = csv_pkg::DEN_W;

  logic [NST-1:0] vld_r;
  logic           en;

  logic [R_W-1:0]    mag_a [3];
  logic [NUM_W-1:0]  num [3];

  // Multiply stage.
  logic [PROD_W-1:0]               prod_r [3];
  logic [csv_pkg::MAGR_W-1:0]      magr_r;
  logic [2:0]                      neg_a_r;
  csv_pkg::side_t                  side_a_r;
  // Numerator stage.
  csv_pkg::div_st_t                st_b_r [3];
  logic [DEN_W-1:0]                den_b_r;
  logic [2:0]                      neg_b_r;
  csv_pkg::side_t                  side_b_r;
  // Quotient stages.
  csv_pkg::div_st_t                dv_r [NDIV][3];
  logic [DEN_W-1:0]                den_r [NDIV];
  logic [2:0]                      neg_r [NDIV];
  csv_pkg::side_t                  side_r [NDIV];
  csv_pkg::out_t                   out_r;

  assign en = !vld_r[NST-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld_r[NST-1];
  assign out_data = out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_a[i] = in_data.side.r[i][R_W-1] ? (~in_data.side.r[i] + 1'b1) : in_data.side.r[i];
      num[i] = {prod_r[i], 1'b0} + NUM_W'(magr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i] <= PROD_W'(mag_a[i]) * PROD_W'(in_data.mag_v);
        neg_a_r[i] <= in_data.side.r[i][R_W-1];
        st_b_r[i].rem <= num[i][NUM_W-1:Q_W];
        st_b_r[i].nq <= num[i][Q_W-1:0];
      end
      magr_r <= in_data.mag_r;
      side_a_r <= in_data.side;
      den_b_r <= {magr_r, 1'b0};
      neg_b_r <= neg_a_r;
      side_b_r <= side_a_r;
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_stage
    csv_pkg::div_st_t  st_prev [3];
    logic [DEN_W-1:0]  den_prev;
    logic [2:0]        neg_prev;
    csv_pkg::side_t    side_prev;

    if (k == 0) begin : g_first
      assign st_prev = st_b_r;
      assign den_prev = den_b_r;
      assign neg_prev = neg_b_r;
      assign side_prev = side_b_r;
    end else begin : g_next
      assign st_prev = dv_r[k-1];
      assign den_prev = den_r[k-1];
      assign neg_prev = neg_r[k-1];
      assign side_prev = side_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dv_r[k][i] <= csv_pkg::div_step(st_prev[i], den_prev);
        end
        den_r[k] <= den_prev;
        neg_r[k] <= neg_prev;
        side_r[k] <= side_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (side_r[NDIV-1].mode)
        csv_pkg::MODE_PASS: begin
          out_r.out_vx <= side_r[NDIV-1].v[0];
          out_r.out_vy <= side_r[NDIV-1].v[1];
          out_r.out_vz <= side_r[NDIV-1].v[2];
          out_r.moving <= 1'b1;
          out_r.parent_mismatch <= 1'b1;
        end
        csv_pkg::MODE_SLIDE: begin
          out_r.out_vx <= csv_pkg::sat_vel(dv_r[NDIV-1][0].nq, neg_r[NDIV-1][0]);
          out_r.out_vy <= csv_pkg::sat_vel(dv_r[NDIV-1][1].nq, neg_r[NDIV-1][1]);
          out_r.out_vz <= csv_pkg::sat_vel(dv_r[NDIV-1][2].nq, neg_r[NDIV-1][2]);
          out_r.moving <= 1'b1;
          out_r.parent_mismatch <= 1'b0;
        end
        default: begin
          out_r.out_vx <= '0;
          out_r.out_vy <= '0;
          out_r.out_vz <= '0;
          out_r.moving <= 1'b0;
          out_r.parent_mismatch <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/csv_checker.sv */
// Port-level checks for the collision slide velocity block, bound to the
// top level. Depends on csv_pkg and collision_slide_velocity_top.
module csv_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input csv_pkg::out_t out_data
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A parent mismatch always reports the body as moving.
  a_mismatch_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.parent_mismatch |-> out_data.moving)
    else $error("parent mismatch without moving");

  // A stopped body has zero velocity and no mismatch.
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.moving |->
      out_data.out_vx == '0 && out_data.out_vy == '0 && out_data.out_vz == '0 &&
      !out_data.parent_mismatch)
    else $error("stopped body with nonzero velocity");

endmodule

bind collision_slide_velocity_top csv_checker u_csv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .out_data  (out_s.data)
);

/* test/slide_checker.sv */
`timescale 1ns / 1ps
// Checker for the collision slide velocity block: watches both stream channels,
// predicts each result from the stop speed it is told and compares in order.
// Depends on csv_pkg.
module slide_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  csv_pkg::in_t                    in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  csv_pkg::out_t                   out_data,
  input  logic [csv_pkg::STOP_W-1:0]      stop_speed,
  output int                              fail_count,
  output int                              pending,
  output int                              slide_seen,
  output int                              stop_seen,
  output int                              pass_seen
);
  import csv_pkg::*;

  out_t pending_results[$];

  function automatic longint round14(input longint x);
    longint m;
    m = (x < 0) ? -x : x;
    m = (m + 64'sd8192) >>> 14;
    return (x < 0) ? -m : m;
  endfunction

  function automatic longint floor_root(input longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [VEL_W-1:0] clamp_vel(input longint x);
    if (x > 8388607) return VEL_MAX;
    if (x < -8388608) return VEL_MIN;
    return x[VEL_W-1:0];
  endfunction

  function automatic out_t slide_velocity(input in_t it, input logic [STOP_W-1:0] stop);
    out_t o;
    longint v[3];
    longint n[3];
    longint r[3];
    longint dot;
    longint unsigned v2;
    longint unsigned r2;
    longint unsigned mv;
    longint unsigned mr;
    longint unsigned a;
    longint unsigned q;
    v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
    n[0] = it.normal_x; n[1] = it.normal_y; n[2] = it.normal_z;
    o = '0;
    if (!it.same_parent) begin
      o.out_vx = it.vel_x; o.out_vy = it.vel_y; o.out_vz = it.vel_z;
      o.moving = 1'b1;
      o.parent_mismatch = 1'b1;
      return o;
    end
    dot = round14(n[0] * v[0] + n[1] * v[1] + n[2] * v[2]);
    v2 = 0;
    r2 = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = v[i] - round14(n[i] * dot);
      r2 += r[i] * r[i];
      v2 += v[i] * v[i];
    end
    if (r2 > longint'(stop) * longint'(stop)) begin
      mv = floor_root(v2);
      mr = floor_root(r2);
      if (mr == 0) mr = 1;
      for (int i = 0; i < 3; i++) begin
        a = (r[i] < 0) ? -r[i] : r[i];
        q = (2 * a * mv + mr) / (2 * mr);
        r[i] = (r[i] < 0) ? -longint'(q) : longint'(q);
      end
      o.out_vx = clamp_vel(r[0]);
      o.out_vy = clamp_vel(r[1]);
      o.out_vz = clamp_vel(r[2]);
      o.moving = 1'b1;
    end
    return o;
  endfunction

  assign pending = pending_results.size();

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fail_count <= 0;
      slide_seen <= 0;
      stop_seen <= 0;
      pass_seen <= 0;
    end else begin
      if (in_valid && in_ready) pending_results.push_back(slide_velocity(in_data, stop_speed));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          out_t exp_r;
          exp_r = pending_results.pop_front();
          if (exp_r.parent_mismatch) pass_seen <= pass_seen + 1;
          else if (exp_r.moving) slide_seen <= slide_seen + 1;
          else stop_seen <= stop_seen + 1;
          if (exp_r.out_vx !== out_data.out_vx || exp_r.out_vy !== out_data.out_vy ||
              exp_r.out_vz !== out_data.out_vz || exp_r.moving !== out_data.moving ||
              exp_r.parent_mismatch !== out_data.parent_mismatch) begin
            if (fail_count < 10)
              $display("mismatch: expected %p got %p", exp_r, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* test/tb_collision_slide_velocity_top.sv */
`timescale 1ns / 1ps
// Top of the collision slide velocity testbench: clock, reset, stop-speed
// writes, item stimulus with random gaps, and the verdict.
// Depends on csv_pkg, csv_stream_if, the block and slide_checker.
module tb_collision_slide_velocity_top;
  import csv_pkg::*;

  localparam int MAX_CYCLES = 400000;
  localparam int LATENCY = 64;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  // The checker is told the stop speed that the block holds.
  logic [STOP_W-1:0] stop_model;

  // Idling is turned off during a calm stretch; the long hold-off is separate.
  logic calm;
  logic hold_off;
  int cycle_count;
  int fail_count;
  int pending;
  int slide_seen;
  int stop_seen;
  int pass_seen;

  csv_stream_if #(.T(in_t)) in_s ();
  csv_stream_if #(.T(out_t)) out_s ();

  collision_slide_velocity_top dut (
    .clk(clk), .rst_n(rst_n), .in_s(in_s), .out_s(out_s),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  slide_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_s.valid), .in_ready(in_s.ready), .in_data(in_s.data),
    .out_valid(out_s.valid), .out_ready(out_s.ready), .out_data(out_s.data),
    .stop_speed(stop_model), .fail_count(fail_count), .pending(pending),
    .slide_seen(slide_seen), .stop_seen(stop_seen), .pass_seen(pass_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A watchdog on the cycle count catches a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("collision_slide_velocity_top verification failed");
      $finish;
    end
  end

  // The receiver stalls about a third of the time, never when calm outside the
  // hold-off, and all through the hold-off stretch.
  always @(posedge clk) begin
    if (hold_off) out_s.ready <= 1'b0;
    else out_s.ready <= calm || ($urandom_range(99) >= 34);
  end

  // Write the stop speed with a setup and an access cycle, then tell the checker.
  task automatic write_stop(input logic [STOP_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= '0; pwdata <= {{(APB_DW - STOP_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    stop_model <= value;
  endtask

  // Offer one item, idling first at random, and wait for its transfer.
  task automatic send_item(input in_t it);
    while (!calm && $urandom_range(99) < 34) begin
      in_s.valid <= 1'b0;
      @(posedge clk);
    end
    in_s.valid <= 1'b1;
    in_s.data <= it;
    do @(posedge clk); while (!in_s.ready);
  endtask

  // Wait until every result is back, then let the pipeline drain.
  task automatic drain();
    in_s.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  function automatic logic signed [NRM_W-1:0] rand_norm();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sh8000;
      3: return NRM_W'($urandom);
      default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic logic signed [VEL_W-1:0] rand_vel();
    case ($urandom_range(6))
      0: return VEL_MAX;
      1: return VEL_MIN;
      2: return $signed(24'($urandom_range(1024))) - 24'sd512;
      3: return $signed(24'($urandom_range(65536))) - 24'sd32768;
      default: return VEL_W'($urandom);
    endcase
  endfunction

  // Mostly a unit-length axis or a near-unit diagonal, sometimes raw noise.
  function automatic in_t random_item();
    in_t it;
    int axis;
    it.vel_x = rand_vel(); it.vel_y = rand_vel(); it.vel_z = rand_vel();
    it.same_parent = ($urandom_range(9) != 0);
    axis = $urandom_range(9);
    it.normal_x = '0; it.normal_y = '0; it.normal_z = '0;
    if (axis < 3) begin
      case (axis)
        0: it.normal_x = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        1: it.normal_y = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        default: it.normal_z = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      endcase
    end else if (axis < 6) begin
      it.normal_x = $urandom_range(1) ? 16'sd9459 : -16'sd9459;
      it.normal_y = $urandom_range(1) ? 16'sd9459 : -16'sd9459;
      it.normal_z = $urandom_range(1) ? 16'sd9459 : -16'sd9459;
    end else begin
      it.normal_x = rand_norm(); it.normal_y = rand_norm(); it.normal_z = rand_norm();
    end
    return it;
  endfunction

  function automatic in_t make_item(input int vx, input int vy, input int vz,
                                    input int nx, input int ny, input int nz,
                                    input bit same);
    in_t it;
    it.vel_x = VEL_W'(vx); it.vel_y = VEL_W'(vy); it.vel_z = VEL_W'(vz);
    it.normal_x = NRM_W'(nx); it.normal_y = NRM_W'(ny); it.normal_z = NRM_W'(nz);
    it.same_parent = same;
    return it;
  endfunction

  // The receiver's long hold-off runs in its own process, counted in cycles.
  // It starts with the calm stretch, while the sender offers an item every cycle.
  initial begin
    hold_off = 1'b0;
    wait (calm);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [STOP_W-1:0] stops[5];
    cycle_count = 0;
    rst_n = 1'b0;
    calm = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_s.valid = 1'b0; in_s.data = '0;
    out_s.ready = 1'b0;
    stop_model = STOP_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset stop speed: parents differ, every extreme,
    // a non-unit normal, the face-value minimum normal, slow and saturating slides.
    send_item(make_item(-8388608, 8388607, 1, 0, 0, 16384, 0));
    send_item(make_item(8388607, 8388607, 8388607, 16384, 0, 0, 1));
    send_item(make_item(-8388608, -8388608, -8388608, -16384, 0, 0, 1));
    send_item(make_item(8388607, -8388608, 8388607, -32768, -32768, -32768, 1));
    send_item(make_item(-8388608, 8388607, -8388608, 32767, 32767, 32767, 1));
    send_item(make_item(100, 4096, 0, 0, 16384, 0, 1));
    send_item(make_item(0, 0, 0, 0, 0, 0, 1));
    send_item(make_item(4096, 0, 0, 16384, 0, 0, 1));
    send_item(make_item(4096, 206, 0, 16384, 0, 0, 1));
    send_item(make_item(4096, 205, 0, 16384, 0, 0, 1));
    send_item(make_item(8388607, 1, 0, 16383, 0, 0, 1));
    send_item(make_item(-8388608, -1, -1, 16383, 300, -300, 1));
    send_item(make_item(12345, -6789, 4321, 9459, 9459, 9459, 1));
    send_item(make_item(-1, -1, -1, -1, -1, -1, 1));
    send_item(make_item(1, 2, 3, 8192, 0, 0, 1));
    send_item(make_item(0, 0, 0, 0, 0, 0, 0));
    drain();

    // Random items over several stop speeds, the extremes among them.
    stops[0] = '0;
    stops[1] = 23'h7FFFFF;
    stops[2] = STOP_RESET;
    stops[3] = 23'd4096;
    stops[4] = STOP_W'($urandom_range(23'h7FFFFF));
    for (int p = 0; p < 5; p++) begin
      write_stop(stops[p]);
      @(posedge clk);
      for (int k = 0; k < 210; k++) begin
        calm <= (p == 2 && k >= 100 && k < 180);
        send_item(random_item());
      end
      calm <= 1'b0;
      drain();
    end

    $display("Run covered %0d slides, %0d stops and %0d parent mismatches",
             slide_seen, stop_seen, pass_seen);
    $display("across five stop speeds including zero and the maximum.");
    if (fail_count == 0) begin
      $display("collision_slide_velocity_top verification clean");
    end else begin
      $display("collision_slide_velocity_top verification failed");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/csv_pkg.sv
rtl/csv_stream_if.sv
rtl/csv_proj.sv
rtl/csv_sqrt.sv
rtl/csv_div.sv
rtl/collision_slide_velocity_top.sv
rtl/csv_checker.sv
test/slide_checker.sv
test/tb_collision_slide_velocity_top.sv
